[rtl/core/tap_tempo_estimator_defines.svh]
// ---------------------------------------------------------------------------
// Tap tempo estimator assertion macros
// Clocked property wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef TAP_TEMPO_ESTIMATOR_DEFINES_SVH
`define TAP_TEMPO_ESTIMATOR_DEFINES_SVH

// Check on every edge outside reset.
`define TTE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every edge, reset included.
`define TTE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/tte_pkg.sv]
// ---------------------------------------------------------------------------
// Tap tempo estimator package
// Sizes, register codes, reset values and divider request/response types.
// ---------------------------------------------------------------------------
package tte_pkg;

  localparam int unsigned TAP_COUNT  = 4;
  localparam int unsigned SLOT_W     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int unsigned CNT_W      = $clog2(TAP_COUNT + 1);
  localparam int unsigned WRAP_W     = $clog2(2 * TAP_COUNT);
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned BPM_W      = 10;
  // Sum of all held gaps, each at most the widest window.
  localparam int unsigned TOT_W      = $clog2((TAP_COUNT - 1) * ((1 << GAP_W) - 1) + 1);
  localparam int unsigned DIV_W      = TOT_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DIV_W-1:0] TEMPO_NUMER = DIV_W'(60000);

  localparam logic [BPM_W-1:0] MIN_TEMPO_RST    = BPM_W'(40);
  localparam logic [BPM_W-1:0] MAX_TEMPO_RST    = BPM_W'(300);
  localparam logic [GAP_W-1:0] SHORTEST_GAP_RST = GAP_W'(120);
  localparam logic [GAP_W-1:0] LONGEST_GAP_RST  = GAP_W'(2000);

  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_TEMPO    = 2'd0,
    CFG_MAX_TEMPO    = 2'd1,
    CFG_SHORTEST_GAP = 2'd2,
    CFG_LONGEST_GAP  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [GAP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/tte_tap_if.sv]
// ---------------------------------------------------------------------------
// Tap input channel
// Valid/ready channel carrying a tap or clear command with its timestamp.
// ---------------------------------------------------------------------------
interface tte_tap_if;
  import tte_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] tap_time_ms;

  modport source (output valid, output kind, output tap_time_ms, input ready);
  modport sink (input valid, input kind, input tap_time_ms, output ready);
endinterface

[rtl/core/tte_result_if.sv]
// ---------------------------------------------------------------------------
// Tempo result channel
// Valid/ready channel carrying one tempo estimate per tap or clear.
// ---------------------------------------------------------------------------
interface tte_result_if;
  import tte_pkg::*;

  logic             valid;
  logic             ready;
  logic             tempo_valid;
  logic [BPM_W-1:0] tempo_bpm;

  modport source (output valid, output tempo_valid, output tempo_bpm, input ready);
  modport sink (input valid, input tempo_valid, input tempo_bpm, output ready);
endinterface

[rtl/core/tte_cfg_if.sv]
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface tte_cfg_if;
  import tte_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/tte_div.sv]
// ---------------------------------------------------------------------------
// Radix-2 restoring divider
// One quotient bit per cycle; done pulses with the quotient in place.
// ---------------------------------------------------------------------------
module tte_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tte_pkg::div_req_t req_i,
  output tte_pkg::div_rsp_t rsp_o
);
  import tte_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [GAP_W-1:0]     rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [GAP_W-1:0]     dvs_q;
  logic [GAP_W:0]       rem_sh;
  logic [GAP_W:0]       rem_sub;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath: shift in one dividend bit, subtract when it fits.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= fits ? rem_sub[GAP_W-1:0] : rem_sh[GAP_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end else if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/core/tap_tempo_estimator.sv]
// ---------------------------------------------------------------------------
// Tap tempo estimator
// A clear command passes through S_DONE into the result register. A tap
// that yields an average runs S_GAP, S_WRITE, S_RDOLD and S_SUB, then one
// pass through the shared radix-2 divider for the average and, if nonzero,
// a second for the tempo; one that leaves a single tap held skips the divider.
// One item is worked at a time; the next is taken while a result waits.
// Reset (async, active low) empties the history and loads default registers.
// ---------------------------------------------------------------------------
module tap_tempo_estimator (
  input logic           clk_i,
  input logic           rst_ni,
  tte_cfg_if.sink       cfg_i,
  tte_tap_if.sink       tap_i,
  tte_result_if.source  res_o
);
  import tte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_WRITE,
    S_RDOLD,
    S_SUB,
    S_DIV_AVG,
    S_DIV_BPM,
    S_DONE
  } state_e;

  // Configuration registers
  logic [BPM_W-1:0] min_tempo_q;
  logic [BPM_W-1:0] max_tempo_q;
  logic [GAP_W-1:0] shortest_gap_q;
  logic [GAP_W-1:0] longest_gap_q;

  // Control and result registers
  state_e            state_q, state_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic              res_tv_q, res_tv_d;
  logic [BPM_W-1:0]  res_bpm_q, res_bpm_d;
  logic              out_valid_q, out_valid_d;
  logic              out_tv_q, out_tv_d;
  logic [BPM_W-1:0]  out_bpm_q, out_bpm_d;

  // Tap ring: one synchronous memory, read data registered.
  logic [TIME_W-1:0] ring_mem [TAP_COUNT];
  logic [TIME_W-1:0] rdata_q;
  logic              mem_we;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;

  logic [SLOT_W-1:0] last_slot;
  logic [SLOT_W-1:0] next_slot;
  logic [SLOT_W-1:0] oldest_slot;
  logic [WRAP_W-1:0] wrap_sum;
  logic [TIME_W-1:0] diff;
  logic              gap_bad;
  logic              tap_xfer;
  logic [DIV_W-1:0]  quo;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration port: always ready, a write takes effect at its transfer.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_tempo_q    <= MIN_TEMPO_RST;
      max_tempo_q    <= MAX_TEMPO_RST;
      shortest_gap_q <= SHORTEST_GAP_RST;
      longest_gap_q  <= LONGEST_GAP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_MIN_TEMPO:    min_tempo_q    <= cfg_i.data[BPM_W-1:0];
        CFG_MAX_TEMPO:    max_tempo_q    <= cfg_i.data[BPM_W-1:0];
        CFG_SHORTEST_GAP: shortest_gap_q <= cfg_i.data[GAP_W-1:0];
        CFG_LONGEST_GAP:  longest_gap_q  <= cfg_i.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring slot arithmetic, all modulo TAP_COUNT.
  always_comb begin
    last_slot = (slot_q == '0) ? SLOT_W'(TAP_COUNT - 1) : slot_q - 1'b1;
    next_slot = (slot_q == SLOT_W'(TAP_COUNT - 1)) ? '0 : slot_q + 1'b1;
    wrap_sum  = WRAP_W'(slot_q) + WRAP_W'(TAP_COUNT) - WRAP_W'(held_q);
    if (wrap_sum >= WRAP_W'(TAP_COUNT)) begin
      oldest_slot = SLOT_W'(wrap_sum - WRAP_W'(TAP_COUNT));
    end else begin
      oldest_slot = SLOT_W'(wrap_sum);
    end
  end

  // The wrapping difference serves twice: the gap to the newest held tap,
  // and later the span from the oldest held tap. Held gaps each passed the
  // window check, so the span telescopes to the sum of gaps and fits TOT_W.
  assign diff    = now_q - rdata_q;
  assign gap_bad = (diff < TIME_W'(shortest_gap_q)) || (diff > TIME_W'(longest_gap_q));

  assign tap_xfer = tap_i.valid && tap_i.ready;
  assign quo      = div_rsp.quotient;

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    slot_d      = slot_q;
    held_d      = held_q;
    res_tv_d    = res_tv_q;
    res_bpm_d   = res_bpm_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_tv_d    = out_tv_q;
    out_bpm_d   = out_bpm_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = last_slot;
    div_req     = '{start: 1'b0, dividend: TOT_W'(diff), divisor: GAP_W'(held_q - 1'b1)};

    case (state_q)
      S_IDLE: begin
        if (tap_xfer) begin
          if (tap_i.kind == KIND_CLEAR) begin
            // Drop the history; the ring contents are dead past held_q.
            slot_d    = '0;
            held_d    = '0;
            res_tv_d  = 1'b0;
            res_bpm_d = '0;
            state_d   = S_DONE;
          end else begin
            now_d = tap_i.tap_time_ms;
            if (held_q == '0) begin
              state_d = S_WRITE;
            end else begin
              mem_re  = 1'b1;
              state_d = S_GAP;
            end
          end
        end
      end
      S_GAP: begin
        if (gap_bad) begin
          slot_d = '0;
          held_d = '0;
        end
        state_d = S_WRITE;
      end
      S_WRITE: begin
        mem_we = 1'b1;
        slot_d = next_slot;
        if (held_q != CNT_W'(TAP_COUNT)) begin
          held_d = held_q + 1'b1;
        end
        if (held_q == '0) begin
          // Single tap held: nothing to average yet.
          res_tv_d  = 1'b0;
          res_bpm_d = '0;
          state_d   = S_DONE;
        end else begin
          state_d = S_RDOLD;
        end
      end
      S_RDOLD: begin
        // Oldest slot differs from the one just written since two or more
        // taps are held, and the write completed on entering this state: no hazard.
        mem_re    = 1'b1;
        mem_raddr = oldest_slot;
        state_d   = S_SUB;
      end
      S_SUB: begin
        div_req.start = 1'b1;
        state_d       = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        if (div_rsp.done) begin
          if (quo == '0) begin
            res_tv_d  = 1'b0;
            res_bpm_d = '0;
            state_d   = S_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = TEMPO_NUMER;
            div_req.divisor  = quo[GAP_W-1:0];
            state_d          = S_DIV_BPM;
          end
        end
      end
      S_DIV_BPM: begin
        if (div_rsp.done) begin
          res_tv_d = 1'b1;
          // Lower bound wins when the range is inverted.
          if (quo < DIV_W'(min_tempo_q)) begin
            res_bpm_d = min_tempo_q;
          end else if (quo > DIV_W'(max_tempo_q)) begin
            res_bpm_d = max_tempo_q;
          end else begin
            res_bpm_d = quo[BPM_W-1:0];
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold here until the output register frees up.
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_tv_d    = res_tv_q;
          out_bpm_d   = res_bpm_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      slot_q      <= '0;
      held_q      <= '0;
      res_tv_q    <= 1'b0;
      res_bpm_q   <= '0;
      out_valid_q <= 1'b0;
      out_tv_q    <= 1'b0;
      out_bpm_q   <= '0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      slot_q      <= slot_d;
      held_q      <= held_d;
      res_tv_q    <= res_tv_d;
      res_bpm_q   <= res_bpm_d;
      out_valid_q <= out_valid_d;
      out_tv_q    <= out_tv_d;
      out_bpm_q   <= out_bpm_d;
    end
  end

  // Entries are read only below held_q, so every read hits a written slot.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[slot_q] <= now_q;
    end
    if (mem_re) begin
      rdata_q <= ring_mem[mem_raddr];
    end
  end

  assign tap_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.tempo_valid = out_tv_q;
  assign res_o.tempo_bpm   = out_bpm_q;

endmodule

[rtl/core/tte_chk.sv]
// ---------------------------------------------------------------------------
// Tap tempo estimator port checker
// Watches the tap and result channels and is bound to every instance.
// ---------------------------------------------------------------------------
`include "tap_tempo_estimator_defines.svh"

module tte_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  out_tempo_valid_i,
  input logic [tte_pkg::BPM_W-1:0] out_tempo_bpm_i
);
  import tte_pkg::*;

  `TTE_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_tempo_valid_i) && $stable(out_tempo_bpm_i), "stalled result changed")

  `TTE_ASSERT(a_bpm_zero, out_valid_i && !out_tempo_valid_i |-> out_tempo_bpm_i == '0, "tempo without valid flag is not zero")

  `TTE_ASSERT(a_one_item, in_valid_i && in_ready_i |=> !in_ready_i, "second item taken while one is in work")

  `TTE_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_i && in_ready_i, "channels not quiet in reset")

endmodule

bind tap_tempo_estimator tte_chk u_tte_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (tap_i.valid),
  .in_ready_i        (tap_i.ready),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .out_tempo_valid_i (res_o.tempo_valid),
  .out_tempo_bpm_i   (res_o.tempo_bpm)
);

[sim/tb.sv]
// ---------------------------------------------------------------------------
// Tap tempo estimator testbench
// Drives taps and clear commands over the tap channel, writes the window and
// tempo registers between phases, and checks every tempo result in order
// against a typed tempo or a cycle-free model of the tap history here.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tte_pkg::*;

  localparam logic KIND_TAP = 1'b0;

  // Cycles without any transfer before the run is declared hung. A tap's
  // work, the random idle and stall gaps on each side and the short settle
  // pause add up to far less, so a healthy run never gets close.
  localparam int unsigned QUIET_LIMIT = 2000;

  // Cycles to wait for stray results once nothing is due any more.
  localparam int unsigned TAIL_CYCLES = 60;

  localparam int unsigned PHASES     = 7;
  localparam int unsigned PHASE_TAPS = 107;

  typedef struct packed {
    logic             tempo_valid;
    logic [BPM_W-1:0] tempo_bpm;
  } tempo_t;

  typedef enum logic [1:0] {
    ACT_TAP,
    ACT_CLEAR,
    ACT_SETUP
  } row_act_e;

  // For ACT_SETUP the value holds four 16-bit register words:
  // {min_tempo, max_tempo, shortest_gap_ms, longest_gap_ms}.
  typedef struct packed {
    row_act_e          act;
    logic [TIME_W-1:0] value;
    logic              typed;
    logic              exp_valid;
    logic [BPM_W-1:0]  exp_bpm;
  } row_t;

  localparam row_t DIRECTED [26] = '{
    // Reset window 120..2000 ms, range 40..300 bpm.
    '{ACT_TAP,   64'd0,     1'b1, 1'b0, 10'd0},    // single tap, no tempo yet
    '{ACT_TAP,   64'd500,   1'b1, 1'b1, 10'd120},
    '{ACT_TAP,   64'd1000,  1'b1, 1'b1, 10'd120},
    '{ACT_TAP,   64'd1250,  1'b0, 1'b0, 10'd0},    // ring fills up
    '{ACT_TAP,   64'd1370,  1'b0, 1'b0, 10'd0},    // gap right at the lower edge
    '{ACT_TAP,   64'd3370,  1'b0, 1'b0, 10'd0},    // gap right at the upper edge
    '{ACT_TAP,   64'd3489,  1'b1, 1'b0, 10'd0},    // one below: history restarts
    '{ACT_TAP,   64'd5490,  1'b1, 1'b0, 10'd0},    // one above: history restarts
    '{ACT_TAP,   64'd5000,  1'b1, 1'b0, 10'd0},    // time runs backwards
    '{ACT_TAP,   64'd5120,  1'b1, 1'b1, 10'd300},  // 500 bpm clamps to the ceiling
    '{ACT_TAP,   64'd7120,  1'b0, 1'b0, 10'd0},
    '{ACT_TAP,   64'd9120,  1'b0, 1'b0, 10'd0},
    '{ACT_TAP,   64'd11120, 1'b1, 1'b1, 10'd40},   // 30 bpm clamps to the floor
    '{ACT_CLEAR, 64'd0,     1'b1, 1'b0, 10'd0},
    '{ACT_TAP,   64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b0, 10'd0},
    '{ACT_TAP,   64'h0000_0000_0000_0100, 1'b0, 1'b0, 10'd0}, // gap wraps past 2^64
    '{ACT_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 10'd0},
    // Widest window, range 1..1000 bpm.
    '{ACT_SETUP, 64'h0001_03E8_0000_FFFF, 1'b0, 1'b0, 10'd0},
    '{ACT_TAP,   64'd100,   1'b1, 1'b0, 10'd0},
    '{ACT_TAP,   64'd100,   1'b1, 1'b0, 10'd0},    // zero average gap
    '{ACT_TAP,   64'd65635, 1'b0, 1'b0, 10'd0},    // largest gap the window takes
    '{ACT_TAP,   64'd65636, 1'b0, 1'b0, 10'd0},
    // Inverted range: floor 500 above ceiling 100.
    '{ACT_SETUP, 64'h01F4_0064_0078_07D0, 1'b0, 1'b0, 10'd0},
    '{ACT_TAP,   64'd200000, 1'b1, 1'b0, 10'd0},
    '{ACT_TAP,   64'd200600, 1'b1, 1'b1, 10'd500}, // below the floor gives the floor
    '{ACT_TAP,   64'd200720, 1'b0, 1'b0, 10'd0}
  };

  logic clk_i;
  logic rst_ni;

  tte_cfg_if    cfg ();
  tte_tap_if    tap ();
  tte_result_if res ();

  tap_tempo_estimator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .tap_i  (tap),
    .res_o  (res)
  );

  // Model of the tap history and the register file.
  logic [TIME_W-1:0] tap_hist [TAP_COUNT];
  int unsigned       hist_len;
  int unsigned       hist_slot;
  logic [BPM_W-1:0]  bpm_floor;
  logic [BPM_W-1:0]  bpm_ceiling;
  logic [GAP_W-1:0]  gap_floor;
  logic [GAP_W-1:0]  gap_ceiling;

  tempo_t      tempo_due [$];
  int unsigned tempo_errors;
  int unsigned quiet_cycles;
  bit          no_idle;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic void forget_taps();
    for (int i = 0; i < TAP_COUNT; i++) begin
      tap_hist[i] = '0;
    end
    hist_len  = 0;
    hist_slot = 0;
  endfunction

  // Advance the history by one item and return the tempo it yields.
  function automatic tempo_t estimate_tempo(input logic kind, input logic [TIME_W-1:0] stamp);
    tempo_t            est;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] sum;
    logic [TIME_W-1:0] avg;
    logic [TIME_W-1:0] bpm;
    int unsigned       first;
    est = '0;
    if (kind == KIND_CLEAR) begin
      forget_taps();
      return est;
    end
    // A gap outside the window starts a new train; wrap-around makes a
    // backwards step huge.
    if (hist_len > 0) begin
      gap = stamp - tap_hist[(hist_slot + TAP_COUNT - 1) % TAP_COUNT];
      if (gap < TIME_W'(gap_floor) || gap > TIME_W'(gap_ceiling)) begin
        forget_taps();
      end
    end
    tap_hist[hist_slot] = stamp;
    hist_slot = (hist_slot + 1) % TAP_COUNT;
    if (hist_len < TAP_COUNT) begin
      hist_len++;
    end
    if (hist_len < 2) begin
      return est;
    end
    first = (hist_slot + TAP_COUNT - hist_len) % TAP_COUNT;
    sum = '0;
    for (int unsigned k = 1; k < hist_len; k++) begin
      sum += tap_hist[(first + k) % TAP_COUNT] - tap_hist[(first + k - 1) % TAP_COUNT];
    end
    avg = sum / TIME_W'(hist_len - 1);
    if (avg == 0) begin
      return est;
    end
    bpm = TIME_W'(60000) / avg;
    // Floor wins over the ceiling when the range is inverted.
    if (bpm < TIME_W'(bpm_floor)) begin
      bpm = TIME_W'(bpm_floor);
    end else if (bpm > TIME_W'(bpm_ceiling)) begin
      bpm = TIME_W'(bpm_ceiling);
    end
    est.tempo_valid = 1'b1;
    est.tempo_bpm   = bpm[BPM_W-1:0];
    return est;
  endfunction

  // Hold the register write until it transfers, then update the model.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] word);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= word;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      CFG_MIN_TEMPO:    bpm_floor   = word[BPM_W-1:0];
      CFG_MAX_TEMPO:    bpm_ceiling = word[BPM_W-1:0];
      CFG_SHORTEST_GAP: gap_floor   = word[GAP_W-1:0];
      CFG_LONGEST_GAP:  gap_ceiling = word[GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [63:0] words);
    write_reg(CFG_MIN_TEMPO,    words[63:48]);
    write_reg(CFG_MAX_TEMPO,    words[47:32]);
    write_reg(CFG_SHORTEST_GAP, words[31:16]);
    write_reg(CFG_LONGEST_GAP,  words[15:0]);
    cfg.valid <= 1'b0;
  endtask

  // Drop valid and hold off until every due tempo has come back, then pause
  // to let the block fall idle before the registers change.
  task automatic settle();
    tap.valid <= 1'b0;
    while (tempo_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Present one item after a random idle gap; on transfer record either the
  // tempo typed into the table or the one the model works out.
  task automatic send_item(input logic kind, input logic [TIME_W-1:0] stamp,
                           input logic typed, input tempo_t typed_tempo);
    int unsigned idle;
    tempo_t      est;
    idle = no_idle ? 0 : $urandom_range(8);
    if (idle > 0) begin
      tap.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    // Keep valid high across back-to-back items; only the payload changes.
    tap.valid       <= 1'b1;
    tap.kind        <= kind;
    tap.tap_time_ms <= stamp;
    do @(posedge clk_i); while (!tap.ready);
    est = estimate_tempo(kind, stamp);
    tempo_due.push_back(typed ? typed_tempo : est);
  endtask

  // Result side: stall a random number of cycles per result, none inside
  // the no-idle stretches.
  always begin : result_sink
    int unsigned stall;
    stall = no_idle ? 0 : $urandom_range(8);
    if (stall > 0) begin
      res.ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
    res.ready <= 1'b1;
    do @(posedge clk_i); while (!(res.valid && res.ready));
  end

  // Compare each transferred result with the oldest due tempo.
  always @(posedge clk_i) begin : check_tempo
    tempo_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (tempo_due.size() == 0) begin
        $display("%0t ns: tempo result with nothing due: expected none, got valid=%0b bpm=%0d",
                 $time, res.tempo_valid, res.tempo_bpm);
        tempo_errors++;
      end else begin
        want = tempo_due.pop_front();
        if (res.tempo_valid !== want.tempo_valid) begin
          $display("%0t ns: tempo_valid mismatch: expected %0b, got %0b",
                   $time, want.tempo_valid, res.tempo_valid);
          tempo_errors++;
        end
        if (res.tempo_bpm !== want.tempo_bpm) begin
          $display("%0t ns: tempo_bpm mismatch: expected %0d, got %0d",
                   $time, want.tempo_bpm, res.tempo_bpm);
          tempo_errors++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((tap.valid && tap.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t              row;
    logic [63:0]       setting;
    logic [TIME_W-1:0] clock_ms;
    int unsigned       roll;
    int unsigned       lo;
    tempo_errors    = 0;
    quiet_cycles    = 0;
    no_idle         = 1'b0;
    rst_ni          <= 1'b0;
    cfg.valid       <= 1'b0;
    cfg.index       <= CFG_MIN_TEMPO;
    cfg.data        <= '0;
    tap.valid       <= 1'b0;
    tap.kind        <= KIND_TAP;
    tap.tap_time_ms <= '0;
    forget_taps();
    bpm_floor   = MIN_TEMPO_RST;
    bpm_ceiling = MAX_TEMPO_RST;
    gap_floor   = SHORTEST_GAP_RST;
    gap_ceiling = LONGEST_GAP_RST;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: edges of the window, clamping, wrap and clear.
    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      case (row.act)
        ACT_SETUP: begin
          settle();
          set_registers(row.value);
        end
        ACT_CLEAR: send_item(KIND_CLEAR, row.value, row.typed, {row.exp_valid, row.exp_bpm});
        default:   send_item(KIND_TAP, row.value, row.typed, {row.exp_valid, row.exp_bpm});
      endcase
    end

    // Random phases: mostly tap trains inside the window, with restarts,
    // backwards steps, jumps and clears mixed in.
    clock_ms = {$urandom, $urandom};
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: setting = {16'(MIN_TEMPO_RST), 16'(MAX_TEMPO_RST),
                      16'(SHORTEST_GAP_RST), 16'(LONGEST_GAP_RST)};
        1: setting = {16'd1, 16'd1000, 16'd0, 16'hFFFF};
        2: setting = {16'($urandom_range(1000, 300)), 16'($urandom_range(200, 1)),
                      16'($urandom_range(200, 60)), 16'($urandom_range(3000, 500))};
        3: setting = {16'd0, 16'h03FF, 16'd2000, 16'd100};  // empty window
        4: setting = {16'd0, 16'd0, 16'd0, 16'd20};         // zero ceiling, fast taps
        5: setting = {$urandom, $urandom};                  // raw words, masked bits set
        default: begin
          lo = $urandom_range(400);
          setting = {16'($urandom), 16'($urandom), 16'(lo), 16'($urandom_range(65535, lo))};
        end
      endcase
      settle();
      set_registers(setting);
      for (int n = 0; n < PHASE_TAPS; n++) begin
        no_idle = (n < 15);
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_item(KIND_CLEAR, {$urandom, $urandom}, 1'b0, '0);
        end else begin
          if (roll < 8) begin
            clock_ms = {$urandom, $urandom};
          end else if (roll < 12) begin
            clock_ms = clock_ms - $urandom_range(5000, 1);
          end else if (roll < 20) begin
            if (gap_floor != 0 && $urandom_range(1) == 1) begin
              clock_ms = clock_ms + $urandom_range(int'(gap_floor) - 1, 0);
            end else begin
              clock_ms = clock_ms + gap_ceiling + $urandom_range(3000, 1);
            end
          end else begin
            clock_ms = clock_ms + $urandom_range(gap_ceiling, gap_floor);
          end
          send_item(KIND_TAP, clock_ms, 1'b0, '0);
        end
      end
      no_idle = 1'b0;
    end

    // Drain, then watch a while longer for stray results.
    tap.valid <= 1'b0;
    while (tempo_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tempo_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tte_pkg.sv
rtl/core/tte_tap_if.sv
rtl/core/tte_result_if.sv
rtl/core/tte_cfg_if.sv
rtl/core/tte_div.sv
rtl/core/tap_tempo_estimator.sv
rtl/core/tte_chk.sv
sim/tb.sv
